>>> src/levenshtein_trie_row_step_top_assert.svh
// ----------------------------------------------------------------------------
// levenshtein trie row step: assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_TRIE_ROW_STEP_TOP_ASSERT_SVH
`define LEVENSHTEIN_TRIE_ROW_STEP_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LTRS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LTRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ltrs_pkg.sv
// ----------------------------------------------------------------------------
// ltrs_pkg
// types, constants and helpers shared by the trie row step block
// ----------------------------------------------------------------------------
package ltrs_pkg;

  localparam int WORD_MAX_DEF  = 32;
  localparam int DEPTH_MAX_DEF = 32;

  localparam int ENTRY_W      = 6;
  localparam logic [ENTRY_W-1:0] ENTRY_SAT = 6'd63;
  localparam int CHAR_W       = 8;
  localparam int DEPTH_IN_W   = 6;
  localparam int DEPTH_CMP_W  = 9;
  localparam int QUERY_REGS   = 4;
  localparam int QUERY_REG_W  = 64;
  localparam int QBYTE_W      = 5;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_DATA_W   = 64;

  typedef enum logic [2:0] {
    REG_QUERY_LOW,
    REG_QUERY_SECOND,
    REG_QUERY_THIRD,
    REG_QUERY_HIGH,
    REG_QUERY_LENGTH,
    REG_DISTANCE_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [QUERY_REGS-1:0][QUERY_REG_W-1:0] query;
    logic [ENTRY_W-1:0]                     query_length;
    logic [ENTRY_W-1:0]                     distance_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_DRAIN,
    ENG_DONE
  } eng_state_t;

  function automatic logic [ENTRY_W-1:0] sat_inc(input logic [ENTRY_W-1:0] v);
    return (v == ENTRY_SAT) ? ENTRY_SAT : v + 1'b1;
  endfunction

  function automatic logic [ENTRY_W-1:0] min_entry(input logic [ENTRY_W-1:0] a,
                                                   input logic [ENTRY_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

>>> src/ltrs_ram.sv
// ----------------------------------------------------------------------------
// ltrs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ltrs_ram
  import ltrs_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = DEPTH_MAX_DEF * 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ltrs_cfg.sv
// ----------------------------------------------------------------------------
// ltrs_cfg
// apb register file: query bytes, query length and distance limit
// ----------------------------------------------------------------------------
module ltrs_cfg
  import ltrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_reg_t reg_sel;
  logic     wr_strobe;

  assign reg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_strobe) begin
      case (reg_sel)
        REG_QUERY_LOW:      cfg.query[0] <= pwdata;
        REG_QUERY_SECOND:   cfg.query[1] <= pwdata;
        REG_QUERY_THIRD:    cfg.query[2] <= pwdata;
        REG_QUERY_HIGH:     cfg.query[3] <= pwdata;
        REG_QUERY_LENGTH:   cfg.query_length <= pwdata[ENTRY_W-1:0];
        REG_DISTANCE_LIMIT: cfg.distance_limit <= pwdata[ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_QUERY_LOW:      prdata = cfg.query[0];
      REG_QUERY_SECOND:   prdata = cfg.query[1];
      REG_QUERY_THIRD:    prdata = cfg.query[2];
      REG_QUERY_HIGH:     prdata = cfg.query[3];
      REG_QUERY_LENGTH:   prdata = CFG_DATA_W'(cfg.query_length);
      REG_DISTANCE_LIMIT: prdata = CFG_DATA_W'(cfg.distance_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> src/ltrs_row_engine.sv
// ----------------------------------------------------------------------------
// ltrs_row_engine
// walks one dp row entry per cycle: reads the parent entry from the row
// memory, forms the new entry and writes it back into the row of this depth
// ----------------------------------------------------------------------------
`include "levenshtein_trie_row_step_top_assert.svh"

module ltrs_row_engine
  import ltrs_pkg::*;
#(
  parameter int WORD_MAX  = WORD_MAX_DEF,
  parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_IN_W-1:0] tree_depth,
  input  logic [CHAR_W-1:0]     node_char,
  input  logic                  ends_word,
  output logic                  res_valid,
  input  logic                  res_take,
  output logic [ENTRY_W-1:0]    res_dist,
  output logic                  res_match,
  output logic                  res_keep,
  output logic [ENTRY_W-1:0]    res_min
);

  localparam int IDX_W     = $clog2(WORD_MAX + 1);
  localparam int ROW_W     = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
  localparam int RAM_DEPTH = DEPTH_MAX << IDX_W;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  eng_state_t state, state_next;

  logic                   start;
  logic                   issue;
  logic [DEPTH_CMP_W-1:0] depth_ext;
  logic [DEPTH_CMP_W-1:0] depth_clamp;
  logic [ENTRY_W-1:0]     n_sat;

  logic [IDX_W-1:0]  n_reg;
  logic [IDX_W-1:0]  rd_idx;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  logic              depth_one;
  logic [CHAR_W-1:0] ch_reg;
  logic              ends_reg;

  logic               p_valid;
  logic [IDX_W-1:0]   p_idx;
  logic               p_last;
  logic [ENTRY_W-1:0] prev_par;
  logic [ENTRY_W-1:0] prev_cur;
  logic [ENTRY_W-1:0] rmin;

  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] par;
  logic [ENTRY_W-1:0] rep;
  logic [ENTRY_W-1:0] cur;
  logic [ENTRY_W-1:0] rmin_new;
  logic [QBYTE_W-1:0] qsel;
  logic [CHAR_W-1:0]  qbyte;

  // depth zero behaves as depth one, deep nodes share the last row
  assign depth_ext   = DEPTH_CMP_W'(tree_depth);
  assign depth_clamp = (depth_ext == '0) ? DEPTH_CMP_W'(1) :
                       (depth_ext > DEPTH_CMP_W'(DEPTH_MAX)) ? DEPTH_CMP_W'(DEPTH_MAX) :
                       depth_ext;
  assign n_sat = (cfg.query_length > ENTRY_W'(WORD_MAX)) ? ENTRY_W'(WORD_MAX) :
                 cfg.query_length;

  assign start = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE:  if (in_valid) state_next = ENG_RUN;
      ENG_RUN:   if (rd_idx == n_reg) state_next = ENG_DRAIN;
      ENG_DRAIN: state_next = ENG_DONE;
      ENG_DONE:  if (res_take) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    issue     = 1'b0;
    res_valid = 1'b0;
    case (state)
      ENG_IDLE:  in_stall = 1'b0;
      ENG_RUN:   issue = 1'b1;
      ENG_DRAIN: ;
      ENG_DONE:  res_valid = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ENG_IDLE;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_reg     <= IDX_W'(n_sat);
      rd_idx    <= '0;
      wr_row    <= ROW_W'(depth_clamp - DEPTH_CMP_W'(1));
      rd_row    <= ROW_W'(depth_clamp - DEPTH_CMP_W'(2));
      depth_one <= (depth_clamp == DEPTH_CMP_W'(1));
      ch_reg    <= node_char;
      ends_reg  <= ends_word;
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (issue) begin
      p_idx <= rd_idx;
    end
  end

  // the row of depth one is 0..n and never comes from memory; the sequencer
  // only starts an item after every write of the one before has landed
  ltrs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (p_valid),
    .wr_addr(ADDR_W'({wr_row, p_idx})),
    .wr_data(cur),
    .rd_en  (issue),
    .rd_addr(ADDR_W'({rd_row, rd_idx})),
    .rd_data(rd_data)
  );

  assign qsel  = QBYTE_W'(p_idx - 1'b1);
  assign qbyte = cfg.query[qsel[QBYTE_W-1:3]][{qsel[2:0], 3'b000} +: CHAR_W];
  assign par   = depth_one ? ENTRY_W'(p_idx) : rd_data;
  assign rep   = (ch_reg != qbyte) ? sat_inc(prev_par) : prev_par;
  assign p_last = (p_idx == n_reg);

  always_comb begin
    if (p_idx == '0) begin
      cur      = sat_inc(par);
      rmin_new = cur;
    end else begin
      cur      = min_entry(min_entry(sat_inc(prev_cur), sat_inc(par)), rep);
      rmin_new = min_entry(rmin, cur);
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      prev_par <= par;
      prev_cur <= cur;
      rmin     <= rmin_new;
      if (p_last) begin
        res_dist  <= cur;
        res_min   <= rmin_new;
        res_match <= ends_reg && (cur <= cfg.distance_limit);
        res_keep  <= (rmin_new <= cfg.distance_limit);
      end
    end
  end

  `LTRS_ASSERT_HOLDS(a_pipe_in_walk, clk, rst, p_valid,
    (state == ENG_RUN) || (state == ENG_DRAIN), "row entry computed outside a walk")
  `LTRS_ASSERT_HOLDS(a_rows_apart, clk, rst, (state == ENG_RUN) && !depth_one,
    rd_row != wr_row, "parent row and new row share an address range")
  `LTRS_ASSERT_HOLDS(a_idx_in_row, clk, rst, p_valid, p_idx <= n_reg,
    "row entry index beyond query length")
  `LTRS_ASSERT_NEXT(a_last_entry, clk, rst, (state == ENG_RUN) && (rd_idx == n_reg),
    (state == ENG_DRAIN) && p_valid && p_last, "last row entry not computed in drain")

endmodule

>>> src/levenshtein_trie_row_step_top.sv
// an item of query length n walks row entries 0..n, drains, then yields a result word
// the engine takes no new item before the last is through, paced by the serial walk of
// the row entries through the single read port of the row memory, one entry per cycle
// reset clears control and configuration state but not the row memory, and the block
// trusts the user: a parent row is read only after an item at the depth above wrote it
// ----------------------------------------------------------------------------
// levenshtein_trie_row_step_top
// edit-distance dp row per trie character, with apb configuration port
// ----------------------------------------------------------------------------
module levenshtein_trie_row_step_top
  import ltrs_pkg::*;
#(
  parameter int WORD_MAX  = WORD_MAX_DEF,
  parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_IN_W-1:0] tree_depth,
  input  logic [CHAR_W-1:0]     node_char,
  input  logic                  ends_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ENTRY_W-1:0]    distance,
  output logic                  is_match,
  output logic                  keep_descending,
  output logic [ENTRY_W-1:0]    row_minimum
);

  cfg_t               cfg;
  logic               res_valid;
  logic               res_take;
  logic [ENTRY_W-1:0] res_dist;
  logic               res_match;
  logic               res_keep;
  logic [ENTRY_W-1:0] res_min;
  logic               out_valid_next;

  ltrs_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ltrs_row_engine #(
    .WORD_MAX (WORD_MAX),
    .DEPTH_MAX(DEPTH_MAX)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tree_depth(tree_depth),
    .node_char (node_char),
    .ends_word (ends_word),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_dist  (res_dist),
    .res_match (res_match),
    .res_keep  (res_keep),
    .res_min   (res_min)
  );

  // output word register, frees the engine while a result waits
  assign res_take       = res_valid && (!out_valid || !out_stall);
  assign out_valid_next = res_take || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      distance        <= res_dist;
      is_match        <= res_match;
      keep_descending <= res_keep;
      row_minimum     <= res_min;
    end
  end

endmodule

>>> dv/tb_levenshtein_trie_row_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_levenshtein_trie_row_step_top
// drives trie walks into the row step block and checks every result word
// against a local edit-distance row predictor, under random gaps and stalls,
// across several query, length and limit settings written over apb
// ----------------------------------------------------------------------------
module tb_levenshtein_trie_row_step_top;
  import ltrs_pkg::*;

  typedef struct packed {
    logic [ENTRY_W-1:0] distance;
    logic               is_match;
    logic               keep_descending;
    logic [ENTRY_W-1:0] row_minimum;
  } row_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [DEPTH_IN_W-1:0] tree_depth;
  logic [CHAR_W-1:0]     node_char;
  logic                  ends_word;
  logic                  out_valid;
  logic                  out_stall;
  logic [ENTRY_W-1:0]    distance;
  logic                  is_match;
  logic                  keep_descending;
  logic [ENTRY_W-1:0]    row_minimum;

  // predictor copy of the registers and of the stored rows
  logic [QUERY_REG_W-1:0] query_words [QUERY_REGS];
  logic [ENTRY_W-1:0]     word_len;
  logic [ENTRY_W-1:0]     limit_copy;
  logic [ENTRY_W-1:0]     trie_rows [1:32][0:32];
  int                     rows_ready;

  row_result_t expected_rows [$];
  row_result_t oldest_row;

  int  error_count;
  int  items_sent;
  int  rows_checked;
  int  match_count;
  int  settings_count;
  int  deepest_row;
  bit  calm;

  levenshtein_trie_row_step_top DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .tree_depth      (tree_depth),
    .node_char       (node_char),
    .ends_word       (ends_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .distance        (distance),
    .is_match        (is_match),
    .keep_descending (keep_descending),
    .row_minimum     (row_minimum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [ENTRY_W-1:0] bump_sat(input logic [ENTRY_W-1:0] v);
    return (v == 6'd63) ? 6'd63 : v + 6'd1;
  endfunction

  function automatic logic [7:0] q_byte(input int pos);
    return query_words[(pos >> 3) & 3][(pos & 7) * 8 +: 8];
  endfunction

  // new dp row for one trie character; stores it and returns the result word
  function automatic row_result_t predict_row(input logic [5:0] raw_depth,
                                              input logic [7:0] ch,
                                              input logic fin);
    int                 d;
    int                 n;
    int                 i;
    logic [ENTRY_W-1:0] par [0:32];
    logic [ENTRY_W-1:0] cur [0:32];
    logic [ENTRY_W-1:0] best;
    logic [ENTRY_W-1:0] del;
    logic [ENTRY_W-1:0] rep;
    logic [ENTRY_W-1:0] rmin;
    row_result_t        r;
    d = (raw_depth == 6'd0) ? 1 : int'(raw_depth);
    if (d > 32) d = 32;
    n = (word_len > 6'd32) ? 32 : int'(word_len);
    for (i = 0; i <= n; i++) begin
      par[i] = (d == 1) ? 6'(i) : trie_rows[d-1][i];
    end
    cur[0] = bump_sat(par[0]);
    rmin = cur[0];
    for (i = 1; i <= n; i++) begin
      best = bump_sat(cur[i-1]);
      del = bump_sat(par[i]);
      rep = par[i-1];
      if (ch != q_byte(i - 1)) rep = bump_sat(rep);
      if (del < best) best = del;
      if (rep < best) best = rep;
      cur[i] = best;
      if (best < rmin) rmin = best;
    end
    for (i = 0; i <= n; i++) begin
      trie_rows[d][i] = cur[i];
    end
    if (d > rows_ready) rows_ready = d;
    if (d > deepest_row) deepest_row = d;
    r.distance = cur[n];
    r.is_match = fin && (cur[n] <= limit_copy);
    r.keep_descending = (rmin <= limit_copy);
    r.row_minimum = rmin;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", rows_checked, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result word, distance", distance, 0);
      end else begin
        oldest_row = expected_rows.pop_front();
        if (distance !== oldest_row.distance)
          report_mismatch("distance", distance, oldest_row.distance);
        if (is_match !== oldest_row.is_match)
          report_mismatch("is_match", is_match, oldest_row.is_match);
        if (keep_descending !== oldest_row.keep_descending)
          report_mismatch("keep_descending", keep_descending, oldest_row.keep_descending);
        if (row_minimum !== oldest_row.row_minimum)
          report_mismatch("row_minimum", row_minimum, oldest_row.row_minimum);
        if (oldest_row.is_match) match_count++;
      end
      rows_checked++;
    end
  end

  // receiver stalls at random, except during the calm phase
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 27);
    end
  end

  task automatic send_item(input logic [5:0] dep, input logic [7:0] ch, input logic fin);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    tree_depth = dep;
    node_char = ch;
    ends_word = fin;
    do @(posedge clk); while (in_stall);
    expected_rows.push_back(predict_row(dep, ch, fin));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_ADDR_W'(int'(r) * 8);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_QUERY_LOW, REG_QUERY_SECOND, REG_QUERY_THIRD, REG_QUERY_HIGH: begin
        query_words[int'(r)] = v;
      end
      REG_QUERY_LENGTH: begin
        word_len = v[ENTRY_W-1:0];
        // stored rows no longer cover the new length
        rows_ready = 0;
      end
      REG_DISTANCE_LIMIT: begin
        limit_copy = v[ENTRY_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_settings(input logic [63:0] q0, input logic [63:0] q1,
                                input logic [63:0] q2, input logic [63:0] q3,
                                input int len, input int lim);
    logic [63:0] v;
    wait_drained();
    // let the engine finish its last walk before touching registers
    repeat (40) @(posedge clk);
    write_reg(REG_QUERY_LOW, q0);
    write_reg(REG_QUERY_SECOND, q1);
    write_reg(REG_QUERY_THIRD, q2);
    write_reg(REG_QUERY_HIGH, q3);
    v = {$urandom(), $urandom()};
    v[5:0] = 6'(len);
    write_reg(REG_QUERY_LENGTH, v);
    v = {$urandom(), $urandom()};
    v[5:0] = 6'(lim);
    write_reg(REG_DISTANCE_LIMIT, v);
    settings_count++;
  endtask

  function automatic logic [63:0] make_query(input bit narrow);
    logic [63:0] w;
    int          b;
    for (b = 0; b < 8; b++) begin
      w[b*8 +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // depth 1 may also be coded as zero, depth 32 as anything above it
  function automatic logic [5:0] depth_code(input int eff);
    if (eff == 1 && $urandom_range(0, 9) == 0) return 6'd0;
    if (eff == 32 && $urandom_range(0, 1) == 1) return 6'($urandom_range(33, 63));
    return 6'(eff);
  endfunction

  function automatic logic [7:0] pick_char(input int pos);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return q_byte(pos);
    if (r < 75) return q_byte($urandom_range(0, 31));
    return 8'($urandom_range(0, 255));
  endfunction

  // one trie word: branch off a known row and descend
  task automatic run_word();
    int         base;
    int         len;
    int         j;
    int         eff;
    logic [7:0] c;
    logic       fin;
    base = $urandom_range(0, (rows_ready > 31) ? 31 : rows_ready);
    if ($urandom_range(0, 19) == 0) len = 34 - base;
    else len = $urandom_range(1, 6);
    for (j = 1; j <= len; j++) begin
      eff = (base + j > 32) ? 32 : base + j;
      c = pick_char(eff - 1);
      fin = (j == len) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
      send_item(depth_code(eff), c, fin);
    end
  endtask

  task automatic send_noise();
    int eff;
    eff = $urandom_range(1, (rows_ready >= 31) ? 32 : rows_ready + 1);
    send_item(depth_code(eff), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_known_word();
    apply_settings(64'h0000_0000_FF74_6163, 64'd0, 64'd0, 64'd0, 3, 1);
    send_item(6'd0, 8'h63, 1'b0);
    send_item(6'd2, 8'h61, 1'b0);
    send_item(6'd3, 8'h74, 1'b1);
    send_item(6'd3, 8'h70, 1'b1);
    send_item(6'd2, 8'h6F, 1'b0);
    send_item(6'd3, 8'h74, 1'b1);
    send_item(6'd1, 8'hFF, 1'b1);
    send_item(6'd1, 8'h00, 1'b0);
  endtask

  task automatic test_empty_query();
    apply_settings(64'd0, 64'd0, 64'd0, 64'd0, 0, 1);
    send_item(6'd1, 8'h00, 1'b1);
    send_item(6'd2, 8'hFF, 1'b1);
    send_item(6'd1, 8'h5A, 1'b1);
  endtask

  task automatic test_saturated_settings();
    apply_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 63, 63);
    send_item(6'd1, 8'hFF, 1'b1);
    send_item(6'd2, 8'hFF, 1'b1);
    send_item(6'd3, 8'h00, 1'b1);
    send_item(6'd2, 8'hFF, 1'b0);
    send_item(6'd1, 8'h00, 1'b1);
  endtask

  task automatic test_random_walks();
    int ph;
    int len;
    int lim;
    int stop_at;
    bit paused;
    bit narrow;
    paused = 1'b0;
    for (ph = 0; ph < 7; ph++) begin
      narrow = (ph != 5);
      case (ph)
        0: begin len = 5; lim = 1; end
        1: begin len = 32; lim = 4; end
        2: begin len = 0; lim = 0; end
        3: begin len = $urandom_range(1, 12); lim = $urandom_range(0, 5); end
        4: begin len = 63; lim = 63; end
        5: begin len = 20; lim = 32; end
        default: begin len = $urandom_range(0, 63); lim = $urandom_range(0, 63); end
      endcase
      apply_settings(make_query(narrow), make_query(narrow), make_query(narrow),
                     make_query(narrow), len, lim);
      calm = (ph == 3);
      stop_at = items_sent + 250;
      while (items_sent < stop_at) begin
        if (ph == 1 && !paused && items_sent + 130 >= stop_at) begin
          // hold the sender until every outstanding word is back
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 12) send_noise();
        else run_word();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    tree_depth = '0;
    node_char = '0;
    ends_word = 1'b0;
    out_stall = 1'b0;
    calm = 1'b0;
    error_count = 0;
    items_sent = 0;
    rows_checked = 0;
    match_count = 0;
    settings_count = 0;
    deepest_row = 0;
    rows_ready = 0;
    word_len = '0;
    limit_copy = '0;
    for (int k = 0; k < QUERY_REGS; k++) query_words[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_known_word();
    test_empty_query();
    test_saturated_settings();
    test_random_walks();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("sent %0d trie characters under %0d register settings, deepest row %0d",
             items_sent, settings_count, deepest_row);
    $display("checked %0d result words, %0d of them matches, %0d mismatches",
             rows_checked, match_count, error_count);
    if (error_count == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
